/* src/idscp_pkg.sv */
// Shared types, codes and character decode for the identifier parser.
package idscp_pkg;

  // Kind codes, shared by the expectation input and the result
  localparam logic [3:0] KIND_ANY       = 4'd0;
  localparam logic [3:0] KIND_NONE      = 4'd1;
  localparam logic [3:0] KIND_NULL      = 4'd2;
  localparam logic [3:0] KIND_DEC       = 4'd3;
  localparam logic [3:0] KIND_UUID      = 4'd4;
  localparam logic [3:0] KIND_UUID_CAPS = 4'd5;
  localparam logic [3:0] KIND_GOOG      = 4'd6;
  localparam logic [3:0] KIND_B64       = 4'd7;
  localparam logic [3:0] KIND_HEX       = 4'd8;
  localparam logic [3:0] KIND_STRING    = 4'd9;

  // Letter case seen so far in a UUID
  localparam logic [1:0] CASE_UNKNOWN = 2'd0;
  localparam logic [1:0] CASE_LOWER   = 2'd1;
  localparam logic [1:0] CASE_UPPER   = 2'd2;

  // One text byte, classified by the front end
  typedef struct packed {
    logic [7:0] char_byte;
    logic       present;
    logic       last;
    logic [3:0] expected;
    logic       is_dec;
    logic [3:0] dec_val;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       is_lower;
    logic       is_upper;
    logic       goog_ok;
    logic [5:0] goog_val;
    logic       sb_ok;
    logic [5:0] sb_val;
  } char_info_t;

  // Still-valid flags per format
  typedef struct packed {
    logic f_null;
    logic f_zero;
    logic f_uuid;
    logic f_goog;
    logic f_dec;
    logic f_b64;
    logic f_hex;
  } fmt_flags_t;

  localparam fmt_flags_t FLAGS_ALL = '{default: 1'b1};

  // Byte of the literal null at positions 0..3
  function automatic logic [7:0] null_char(input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0:    r = 8'h6e;
      2'd1:    r = 8'h75;
      default: r = 8'h6c;
    endcase
    return r;
  endfunction

  // Byte of the goog128 prefix at positions 0..4
  function automatic logic [7:0] goog_char(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = 8'h43;
      3'd1:    r = 8'h41;
      3'd2:    r = 8'h45;
      3'd3:    r = 8'h53;
      default: r = 8'h45;
    endcase
    return r;
  endfunction

  // Classify one byte against every alphabet
  function automatic char_info_t classify(input logic [7:0] c, input logic present,
                                          input logic last, input logic [3:0] expected);
    char_info_t r;
    logic dig, lo_af, up_af, up_az, lo_az;
    dig   = (c >= 8'h30) && (c <= 8'h39);
    lo_af = (c >= 8'h61) && (c <= 8'h66);
    up_af = (c >= 8'h41) && (c <= 8'h46);
    up_az = (c >= 8'h41) && (c <= 8'h5a);
    lo_az = (c >= 8'h61) && (c <= 8'h7a);
    r.char_byte = c;
    r.present   = present;
    r.last      = last;
    r.expected  = expected;
    r.is_dec    = dig;
    r.dec_val   = 4'(c - 8'h30);
    r.is_lower  = lo_af;
    r.is_upper  = up_af;
    r.hex_ok    = dig || lo_af || up_af;
    if (dig)        r.hex_val = 4'(c - 8'h30);
    else if (lo_af) r.hex_val = 4'(c - 8'h57);
    else            r.hex_val = 4'(c - 8'h37);
    r.goog_ok = dig || up_az || lo_az || (c == 8'h2d) || (c == 8'h5f);
    if (dig)              r.goog_val = 6'(c - 8'h30);
    else if (up_az)       r.goog_val = 6'(c - 8'h37);
    else if (lo_az)       r.goog_val = 6'(c - 8'h3d);
    else if (c == 8'h2d)  r.goog_val = 6'd62;
    else                  r.goog_val = 6'd63;
    r.sb_ok = dig || up_az || lo_az || (c == 8'h2b) || (c == 8'h2f);
    if (dig)              r.sb_val = 6'(c - 8'h2e);
    else if (up_az)       r.sb_val = 6'(c - 8'h35);
    else if (lo_az)       r.sb_val = 6'(c - 8'h3b);
    else if (c == 8'h2b)  r.sb_val = 6'd0;
    else                  r.sb_val = 6'd1;
    return r;
  endfunction

endpackage

/* src/idscp_if.sv */
// Stream interfaces for text bytes in and parse results out.
interface idscp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       byte_present;
  logic       last_byte;
  logic [3:0] expected_type;

  modport source (output valid, char_byte, byte_present, last_byte, expected_type,
                  input ready);
  modport sink   (input valid, char_byte, byte_present, last_byte, expected_type,
                  output ready);
endinterface

interface idscp_out_if #(parameter int LEN_W = 13);
  logic             valid;
  logic             ready;
  logic [3:0]       id_kind;
  logic [63:0]      value_high;
  logic [63:0]      value_low;
  logic [LEN_W-1:0] text_length;
  logic             kind_mismatch;

  modport source (output valid, id_kind, value_high, value_low, text_length,
                  kind_mismatch, input ready);
  modport sink   (input valid, id_kind, value_high, value_low, text_length,
                  kind_mismatch, output ready);
endinterface

/* src/idscp_queue.sv */
// Two-entry queue of classified bytes between front and back.
module idscp_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  idscp_pkg::char_info_t  data_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   empty_o,
  output idscp_pkg::char_info_t  data_o
);

  idscp_pkg::char_info_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

/* src/idscp_front.sv */
// Front end: accept text bytes and classify them into the queue.
module idscp_front (
  idscp_in_if.sink               in_i,
  input  logic                   q_full_i,
  output logic                   push_o,
  output idscp_pkg::char_info_t  info_o
);

  // Accept while the queue has room
  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && !q_full_i;
  assign info_o     = idscp_pkg::classify(in_i.char_byte, in_i.byte_present,
                                          in_i.last_byte, in_i.expected_type);

endmodule

/* src/idscp_back.sv */
// Back end: update per-format accumulators and emit one result per string.
module idscp_back #(
  parameter int MAX_TEXT_LEN = 4096,
  parameter int LEN_W        = 13
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_empty_i,
  input  idscp_pkg::char_info_t  info_i,
  output logic                   pop_o,
  idscp_out_if.source            out_o
);

  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_TEXT_LEN);

  logic [127:0]           hex_q, hex_d, dec_q, dec_d, goog_q, goog_d;
  logic [47:0]            sb0_q, sb0_d, sb1_q, sb1_d;
  logic [LEN_W-1:0]       pos_q, pos_d;
  idscp_pkg::fmt_flags_t  flg_q, flg_d;
  logic [1:0]             lc_q, lc_d;
  logic [3:0]             exp_q, exp_d;

  logic        ov_q, ov_d;
  logic [3:0]  okind_q, okind_d;
  logic [63:0] ohi_q, ohi_d, olo_q, olo_d;
  logic [LEN_W-1:0] olen_q, olen_d;
  logic        omis_q, omis_d;

  logic [LEN_W-1:0] p;
  logic        ends;
  logic [3:0]  e, kind;
  logic [63:0] hi, lo;
  idscp_pkg::char_info_t it;

  assign it    = info_i;
  assign pop_o = !q_empty_i && (!ov_q || out_o.ready);
  assign p     = pos_q;

  assign out_o.valid         = ov_q;
  assign out_o.id_kind       = okind_q;
  assign out_o.value_high    = ohi_q;
  assign out_o.value_low     = olo_q;
  assign out_o.text_length   = olen_q;
  assign out_o.kind_mismatch = omis_q;

  // Next state for one byte, and the result at string end
  always_comb begin
    hex_d = hex_q; dec_d = dec_q; goog_d = goog_q;
    sb0_d = sb0_q; sb1_d = sb1_q; pos_d = pos_q;
    flg_d = flg_q; lc_d = lc_q; exp_d = exp_q;
    ov_d = ov_q && !out_o.ready;
    okind_d = okind_q; ohi_d = ohi_q; olo_d = olo_q;
    olen_d = olen_q; omis_d = omis_q;
    ends = 1'b0; e = exp_q; kind = idscp_pkg::KIND_STRING; hi = '0; lo = '0;
    if (pop_o) begin
      if (pos_q == '0) exp_d = it.expected;
      if (it.present) begin
        // null and single zero
        if (p < LEN_W'(4) && it.char_byte != idscp_pkg::null_char(p[1:0]))
          flg_d.f_null = 1'b0;
        if (p == '0 && it.char_byte != 8'h30) flg_d.f_zero = 1'b0;
        // decimal
        if (!it.is_dec || (p == '0 && it.char_byte == 8'h30)) flg_d.f_dec = 1'b0;
        else if (p < LEN_W'(39))
          dec_d = (dec_q << 3) + (dec_q << 1) + 128'(it.dec_val);
        // uuid and hex
        if (p < LEN_W'(36)) begin
          if (p == LEN_W'(8) || p == LEN_W'(13) || p == LEN_W'(18) || p == LEN_W'(23)) begin
            if (it.char_byte != 8'h2d) flg_d.f_uuid = 1'b0;
          end else if (!it.hex_ok) begin
            flg_d.f_uuid = 1'b0;
          end else if (it.is_lower) begin
            if (lc_q == idscp_pkg::CASE_UPPER) flg_d.f_uuid = 1'b0;
            else lc_d = idscp_pkg::CASE_LOWER;
          end else if (it.is_upper) begin
            if (lc_q == idscp_pkg::CASE_LOWER) flg_d.f_uuid = 1'b0;
            else lc_d = idscp_pkg::CASE_UPPER;
          end
          if (it.hex_ok) hex_d = {hex_q[123:0], it.hex_val};
        end
        if (p < LEN_W'(32) && !it.hex_ok) flg_d.f_hex = 1'b0;
        // goog128
        if (p < LEN_W'(5)) begin
          if (it.char_byte != idscp_pkg::goog_char(p[2:0])) flg_d.f_goog = 1'b0;
        end else if (p < LEN_W'(26)) begin
          if (!it.goog_ok) flg_d.f_goog = 1'b0;
          else goog_d = {goog_q[121:0], it.goog_val};
        end
        // short base64 halves
        if (p < LEN_W'(16)) begin
          if (!it.sb_ok) flg_d.f_b64 = 1'b0;
          else if (!p[3]) sb0_d = {sb0_q[41:0], it.sb_val};
          else sb1_d = {sb1_q[41:0], it.sb_val};
        end
        if (p < MaxLen) pos_d = p + LEN_W'(1);
      end
      ends = !it.present || it.last;
      e = exp_d;
      // Pick the first matching format
      if ((e == idscp_pkg::KIND_ANY || e == idscp_pkg::KIND_NONE) && pos_d == '0) begin
        kind = idscp_pkg::KIND_NONE;
      end else if ((e == idscp_pkg::KIND_ANY || e == idscp_pkg::KIND_NULL)
                   && pos_d == LEN_W'(4) && flg_d.f_null) begin
        kind = idscp_pkg::KIND_NULL;
      end else if ((e == idscp_pkg::KIND_ANY || e == idscp_pkg::KIND_DEC)
                   && pos_d == LEN_W'(1) && flg_d.f_zero) begin
        kind = idscp_pkg::KIND_DEC;
      end else if ((e == idscp_pkg::KIND_ANY || e == idscp_pkg::KIND_UUID
                    || e == idscp_pkg::KIND_UUID_CAPS)
                   && pos_d == LEN_W'(36) && flg_d.f_uuid) begin
        kind = (lc_d == idscp_pkg::CASE_UPPER) ? idscp_pkg::KIND_UUID_CAPS
                                               : idscp_pkg::KIND_UUID;
        hi = hex_d[127:64]; lo = hex_d[63:0];
      end else if ((e == idscp_pkg::KIND_ANY || e == idscp_pkg::KIND_GOOG)
                   && pos_d == LEN_W'(26) && flg_d.f_goog) begin
        kind = idscp_pkg::KIND_GOOG;
        hi = goog_d[127:64]; lo = goog_d[63:0];
      end else if ((e == idscp_pkg::KIND_ANY || e == idscp_pkg::KIND_DEC)
                   && pos_d < LEN_W'(40) && flg_d.f_dec) begin
        kind = idscp_pkg::KIND_DEC;
        hi = dec_d[127:64]; lo = dec_d[63:0];
      end else if ((e == idscp_pkg::KIND_ANY || e == idscp_pkg::KIND_B64)
                   && pos_d == LEN_W'(16) && flg_d.f_b64) begin
        kind = idscp_pkg::KIND_B64;
        hi = {32'd0, sb0_d[47:16]}; lo = {sb0_d[15:0], sb1_d};
      end else if ((e == idscp_pkg::KIND_ANY || e == idscp_pkg::KIND_HEX)
                   && pos_d == LEN_W'(32) && flg_d.f_hex) begin
        kind = idscp_pkg::KIND_HEX;
        hi = hex_d[127:64]; lo = hex_d[63:0];
      end
      if (ends) begin
        ov_d = 1'b1; okind_d = kind; ohi_d = hi; olo_d = lo; olen_d = pos_d;
        omis_d = (e != idscp_pkg::KIND_ANY) && (e != kind);
        hex_d = '0; dec_d = '0; goog_d = '0; sb0_d = '0; sb1_d = '0;
        pos_d = '0; flg_d = idscp_pkg::FLAGS_ALL; lc_d = idscp_pkg::CASE_UNKNOWN;
      end
    end
  end

  // Hold result payload
  always_ff @(posedge clk_i) begin
    okind_q <= okind_d; ohi_q <= ohi_d; olo_q <= olo_d;
    olen_q <= olen_d; omis_q <= omis_d;
  end

  // Hold per-string state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hex_q <= '0; dec_q <= '0; goog_q <= '0; sb0_q <= '0; sb1_q <= '0;
      pos_q <= '0; flg_q <= idscp_pkg::FLAGS_ALL; lc_q <= idscp_pkg::CASE_UNKNOWN;
      exp_q <= idscp_pkg::KIND_ANY; ov_q <= 1'b0;
    end else begin
      hex_q <= hex_d; dec_q <= dec_d; goog_q <= goog_d; sb0_q <= sb0_d; sb1_q <= sb1_d;
      pos_q <= pos_d; flg_q <= flg_d; lc_q <= lc_d; exp_q <= exp_d; ov_q <= ov_d;
    end
  end

endmodule

/* src/id_string_classify_parse.sv */
// Top level of the identifier string classifier and parser.
// Takes one text byte per cycle, sustained while results drain, and tests it against
// every format at once (null, zero, UUID, goog128, decimal, 96-bit base64, hex128).
// A result is registered: its valid rises at the edge at which the back end pops the byte
// ending its string from the queue. The pace is set by the back end's 128-bit accumulator
// update, done once per popped byte. While a result waits, the front keeps taking bytes
// into the two-entry queue until it holds two entries, and then input stalls.
module id_string_classify_parse #(
  parameter int MAX_TEXT_LEN = 4096,
  parameter int LEN_W        = 13
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  idscp_in_if.sink     in_i,
  idscp_out_if.source  out_o
);

  logic                  q_full, q_empty, push, pop;
  idscp_pkg::char_info_t push_info, pop_info;

  // Classify incoming bytes
  idscp_front u_front (
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .info_o   (push_info)
  );

  // Decouple front and back
  idscp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_info),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .data_o  (pop_info)
  );

  // Accumulate and report
  idscp_back #(
    .MAX_TEXT_LEN (MAX_TEXT_LEN),
    .LEN_W        (LEN_W)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .info_i    (pop_info),
    .pop_o     (pop),
    .out_o     (out_o)
  );

`ifndef NO_ASSERTIONS
  a_none_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.id_kind == idscp_pkg::KIND_NONE |-> out_o.text_length == '0)
    else $error("none result with nonzero length");
  a_uuid_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.id_kind == idscp_pkg::KIND_UUID
                    || out_o.id_kind == idscp_pkg::KIND_UUID_CAPS)
    |-> out_o.text_length == LEN_W'(36))
    else $error("uuid result with wrong length");
  a_null_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.id_kind == idscp_pkg::KIND_NULL
    |-> out_o.value_high == '0 && out_o.value_low == '0 && out_o.text_length == LEN_W'(4))
    else $error("null result with value or wrong length");
  a_b64_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.id_kind == idscp_pkg::KIND_B64
    |-> out_o.value_high[63:32] == '0 && out_o.text_length == LEN_W'(16))
    else $error("short base64 result out of range");
`endif

endmodule
